### hdl/mid_pkg.sv
// Shared types, opcode constants and decode helpers for the MOV byte decoder.
`timescale 1ns / 1ps
`default_nettype none

package mid_pkg;

    // Instruction form of the word being gathered.
    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_RM_REG  = 3'd1,
        KIND_IMM_RM  = 3'd2,
        KIND_IMM_REG = 3'd3,
        KIND_MEM_ACC = 3'd4,
        KIND_ACC_MEM = 3'd5,
        KIND_RM_SEG  = 3'd6,
        KIND_SEG_RM  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNKNOWN = 2'd1,
        ERR_TRUNC   = 2'd2
    } err_t;

    // Opcode values and masks used by the classifier.
    localparam logic [7:0] OP_RM_SEG  = 8'b10001110;
    localparam logic [7:0] OP_SEG_RM  = 8'b10001100;
    localparam logic [7:0] OP_IMM_RM  = 8'b11000110;
    localparam logic [7:0] OP_MEM_ACC = 8'b10100000;
    localparam logic [7:0] OP_ACC_MEM = 8'b10100010;
    localparam logic [7:0] OP_RM_REG  = 8'b10001000;
    localparam logic [7:0] OP_IMM_REG = 8'b10110000;
    localparam logic [7:0] MASK_W     = 8'b11111110;
    localparam logic [7:0] MASK_DW    = 8'b11111100;
    localparam logic [7:0] MASK_REG   = 8'b11110000;

    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [2:0] RM_DIRECT  = 3'b110;

    // Bytes of one instruction that the record logic looks at.
    localparam int REC_BYTES = 6;

    typedef logic [REC_BYTES-1:0][7:0] rec_bytes_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         length;
        logic               direction;
        logic               wide;
        logic [1:0]         mode;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic [1:0]         seg_reg;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        err_t               error;
    } rec_t;

    function automatic kind_t classify(input logic [7:0] b);
        kind_t k;
        k = KIND_UNKNOWN;
        if (b == OP_RM_SEG)                   k = KIND_RM_SEG;
        else if (b == OP_SEG_RM)              k = KIND_SEG_RM;
        else if ((b & MASK_W) == OP_IMM_RM)   k = KIND_IMM_RM;
        else if ((b & MASK_W) == OP_MEM_ACC)  k = KIND_MEM_ACC;
        else if ((b & MASK_W) == OP_ACC_MEM)  k = KIND_ACC_MEM;
        else if ((b & MASK_DW) == OP_RM_REG)  k = KIND_RM_REG;
        else if ((b & MASK_REG) == OP_IMM_REG) k = KIND_IMM_REG;
        return k;
    endfunction

    // Displacement bytes that follow a ModRM byte: 0, 1 or 2.
    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] n;
        n = 2'd0;
        if (modrm[7:6] == MOD_DISP8)                               n = 2'd1;
        else if (modrm[7:6] == MOD_DISP16)                         n = 2'd2;
        else if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DIRECT) n = 2'd2;
        return n;
    endfunction

endpackage

`default_nettype wire

### hdl/mid_record.sv
// Builds the decoded record from the gathered bytes of one instruction.
`timescale 1ns / 1ps
`default_nettype none

module mid_record (
    input  wire mid_pkg::kind_t      kind_in,
    input  wire logic [2:0]          length_in,
    input  wire mid_pkg::rec_bytes_t bytes_in,
    output mid_pkg::rec_t            rec
);

    logic [7:0]  op;
    logic [7:0]  modrm;
    logic [1:0]  dl;
    logic [15:0] disp;
    logic [7:0]  imm_lo;
    logic [7:0]  imm_hi;

    assign op    = bytes_in[0];
    assign modrm = bytes_in[1];
    assign dl    = mid_pkg::disp_len(modrm);

    always_comb
    begin
        unique case (dl)
            2'd1:    disp = {{8{bytes_in[2][7]}}, bytes_in[2]};
            2'd2:    disp = {bytes_in[3], bytes_in[2]};
            default: disp = 16'd0;
        endcase
    end

    // imm-rm data starts after the displacement
    always_comb
    begin
        unique case (dl)
            2'd1:    begin imm_lo = bytes_in[3]; imm_hi = bytes_in[4]; end
            2'd2:    begin imm_lo = bytes_in[4]; imm_hi = bytes_in[5]; end
            default: begin imm_lo = bytes_in[2]; imm_hi = bytes_in[3]; end
        endcase
    end

    always_comb
    begin
        rec        = '0;
        rec.kind   = kind_in;
        rec.length = length_in;
        rec.error  = mid_pkg::ERR_NONE;
        unique case (kind_in) inside
            mid_pkg::KIND_RM_REG:
            begin
                rec.direction    = op[1];
                rec.wide         = op[0];
                rec.mode         = modrm[7:6];
                rec.reg_field    = modrm[5:3];
                rec.rm_field     = modrm[2:0];
                rec.displacement = disp;
            end
            mid_pkg::KIND_IMM_RM:
            begin
                rec.wide         = op[0];
                rec.mode         = modrm[7:6];
                rec.rm_field     = modrm[2:0];
                rec.displacement = disp;
                rec.immediate    = {op[0] ? imm_hi : 8'd0, imm_lo};
            end
            mid_pkg::KIND_IMM_REG:
            begin
                rec.wide      = op[3];
                rec.reg_field = op[2:0];
                rec.immediate = {op[3] ? bytes_in[2] : 8'd0, bytes_in[1]};
            end
            mid_pkg::KIND_MEM_ACC, mid_pkg::KIND_ACC_MEM:
            begin
                rec.wide         = op[0];
                rec.displacement = {bytes_in[2], bytes_in[1]};
            end
            mid_pkg::KIND_RM_SEG, mid_pkg::KIND_SEG_RM:
            begin
                rec.mode         = modrm[7:6];
                rec.rm_field     = modrm[2:0];
                rec.seg_reg      = op[4:3];
                rec.displacement = disp;
            end
            default:
            begin
                rec.kind = mid_pkg::KIND_UNKNOWN;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/mid_step.sv
// Per-byte gather state: count, length, kind and byte buffer, plus the step decision.
`timescale 1ns / 1ps
`default_nettype none

module mid_step #(
    parameter int MAX_LEN = 6
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] byte_in,
    input  wire logic       eos_in,
    output logic            emit,
    output mid_pkg::rec_t   rec
);

    logic [2:0]      cnt_reg, cnt_next;
    logic [2:0]      need_reg, need_next;
    mid_pkg::kind_t  kind_reg, kind_next;
    logic [7:0]      buf_reg [MAX_LEN];

    logic [2:0]          cnt_inc;
    logic [2:0]          need_cur;
    logic [2:0]          modrm_len;
    mid_pkg::kind_t      first_kind;
    mid_pkg::rec_bytes_t view;
    mid_pkg::rec_t       full_rec;

    assign first_kind = mid_pkg::classify(byte_in);
    assign cnt_inc    = cnt_reg + 3'd1;

    // Length once the ModRM byte is in hand.
    always_comb
    begin
        modrm_len = 3'd2 + {1'b0, mid_pkg::disp_len(byte_in)};
        if (kind_reg == mid_pkg::KIND_IMM_RM)
        begin
            modrm_len = modrm_len + (buf_reg[0][0] ? 3'd2 : 3'd1);
        end
    end

    assign need_cur = (cnt_inc == 3'd2 && need_reg == 3'd0) ? modrm_len : need_reg;

    // Buffer as it stands with the current byte written in.
    always_comb
    begin
        for (int i = 0; i < mid_pkg::REC_BYTES; i++)
        begin
            view[i] = (cnt_reg != 3'd0 && cnt_reg == 3'(i)) ? byte_in : buf_reg[i];
        end
    end

    mid_record u_record (
        .kind_in   (kind_reg),
        .length_in (need_cur),
        .bytes_in  (view),
        .rec       (full_rec)
    );

    always_comb
    begin
        cnt_next  = cnt_reg;
        need_next = need_reg;
        kind_next = kind_reg;
        emit      = 1'b0;
        rec       = '0;
        if (cnt_reg == 3'd0)
        begin
            if (first_kind == mid_pkg::KIND_UNKNOWN)
            begin
                emit       = 1'b1;
                rec.length = 3'd1;
                rec.error  = mid_pkg::ERR_UNKNOWN;
            end
            else if (eos_in)
            begin
                emit       = 1'b1;
                rec.kind   = first_kind;
                rec.length = 3'd1;
                rec.error  = mid_pkg::ERR_TRUNC;
            end
            else
            begin
                cnt_next  = 3'd1;
                kind_next = first_kind;
                unique case (first_kind) inside
                    mid_pkg::KIND_IMM_REG:
                        need_next = byte_in[3] ? 3'd3 : 3'd2;
                    mid_pkg::KIND_MEM_ACC, mid_pkg::KIND_ACC_MEM:
                        need_next = 3'd3;
                    default:
                        need_next = 3'd0;
                endcase
            end
        end
        else
        begin
            if (need_cur != 3'd0 && cnt_inc >= need_cur)
            begin
                emit      = 1'b1;
                rec       = full_rec;
                cnt_next  = 3'd0;
                need_next = 3'd0;
                kind_next = mid_pkg::KIND_UNKNOWN;
            end
            else if (eos_in)
            begin
                emit       = 1'b1;
                rec.kind   = kind_reg;
                rec.length = cnt_inc;
                rec.error  = mid_pkg::ERR_TRUNC;
                cnt_next   = 3'd0;
                need_next  = 3'd0;
                kind_next  = mid_pkg::KIND_UNKNOWN;
            end
            else
            begin
                cnt_next  = cnt_inc;
                need_next = need_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            need_reg <= 3'd0;
            kind_reg <= mid_pkg::KIND_UNKNOWN;
        end
        else if (fire)
        begin
            cnt_reg  <= cnt_next;
            need_reg <= need_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (fire && cnt_reg == 3'(i))
            begin
                buf_reg[i] <= byte_in;
            end
        end
    end

    // Idle means nothing gathered and no pending form.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 3'd0 |-> need_reg == 3'd0 && kind_reg == mid_pkg::KIND_UNKNOWN)
        else $error("idle state holds stale length or kind");

    a_busy_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 3'd0 |-> kind_reg != mid_pkg::KIND_UNKNOWN && cnt_reg <= 3'd5)
        else $error("gathering without a known form or past the longest form");

    a_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        need_reg == 3'd0 || cnt_reg < need_reg)
        else $error("byte count reached length without a record");

endmodule

`default_nettype wire

### hdl/mov_instruction_byte_decoder_unit.sv
// Top level of the 8086 MOV byte decoder: input register, step logic, record register.
//
// Usage:
//   Code bytes enter on code_valid/code_ready with code_byte and end_of_stream;
//   one word is one byte of the instruction stream. Decoded records leave on
//   rec_valid/rec_ready, one record per finished instruction, one per unknown
//   opcode (length 1, error 1), and one when end_of_stream falls inside an
//   instruction (error 2, length = bytes taken so far).
//   The byte is decoded while it sits in the input register; its record is
//   written into the record register when the byte leaves the input register,
//   and is offered from there. Throughput: one byte per cycle while
//   rec_ready is high; the decode of each byte is a single pass between the
//   two registers.
//   When the receiver stalls with a record held, the byte in the input
//   register waits and code_ready falls once that register is full; nothing
//   is dropped. Reset clears the valid flags and the gather state, so the
//   next byte is taken as an opcode; the byte buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module mov_instruction_byte_decoder_unit #(
    parameter int MAX_LEN = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               code_valid,
    output logic                    code_ready,
    input  wire logic [7:0]         code_byte,
    input  wire logic               end_of_stream,
    output logic                    rec_valid,
    input  wire logic               rec_ready,
    output logic [2:0]              kind,
    output logic [2:0]              length,
    output logic                    direction,
    output logic                    wide,
    output logic [1:0]              mode,
    output logic [2:0]              reg_field,
    output logic [2:0]              rm_field,
    output logic [1:0]              seg_reg,
    output logic signed [15:0]      displacement,
    output logic [15:0]             immediate,
    output logic [1:0]              error
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_eos_reg;
    logic          out_valid_reg;
    mid_pkg::rec_t out_rec_reg;

    logic          step_fire;
    logic          step_emit;
    mid_pkg::rec_t step_rec;

    // A byte is decoded when the record register is free or emptying.
    assign step_fire  = in_valid_reg && (!out_valid_reg || rec_ready);
    assign code_ready = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (code_ready)
        begin
            in_valid_reg <= code_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_valid && code_ready)
        begin
            in_byte_reg <= code_byte;
            in_eos_reg  <= end_of_stream;
        end
    end

    mid_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (step_fire),
        .byte_in (in_byte_reg),
        .eos_in  (in_eos_reg),
        .emit    (step_emit),
        .rec     (step_rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= step_emit;
        end
        else if (rec_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && step_emit)
        begin
            out_rec_reg <= step_rec;
        end
    end

    assign rec_valid    = out_valid_reg;
    assign kind         = out_rec_reg.kind;
    assign length       = out_rec_reg.length;
    assign direction    = out_rec_reg.direction;
    assign wide         = out_rec_reg.wide;
    assign mode         = out_rec_reg.mode;
    assign reg_field    = out_rec_reg.reg_field;
    assign rm_field     = out_rec_reg.rm_field;
    assign seg_reg      = out_rec_reg.seg_reg;
    assign displacement = out_rec_reg.displacement;
    assign immediate    = out_rec_reg.immediate;
    assign error        = out_rec_reg.error;

    a_unknown_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && error == mid_pkg::ERR_UNKNOWN
        |-> length == 3'd1 && kind == mid_pkg::KIND_UNKNOWN)
        else $error("unknown-opcode record with wrong kind or length");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && error == mid_pkg::ERR_NONE
        |-> length >= 3'd2 && length <= 3'd6 && kind != mid_pkg::KIND_UNKNOWN)
        else $error("complete record with impossible length or kind");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> code_ready)
        else $error("input register empty but byte refused");

endmodule

`default_nettype wire

### sim/testbench.sv
// Testbench for the MOV byte decoder: random and directed byte streams with a scoreboard check.
`timescale 1ns / 1ps

module testbench;

    // Opcode bits that select direction and width.
    localparam logic [7:0] BIT_W     = 8'h01;
    localparam logic [7:0] BIT_D     = 8'h02;
    localparam logic [7:0] BIT_REG_W = 8'h08;
    localparam int         IDLE_PCT  = 34;
    localparam int         RAND_BYTES = 1600;

    // Decodes the byte stream on its own and holds the records still owed by the block.
    class mov_record_checker;
        mid_pkg::kind_t gather_kind = mid_pkg::KIND_UNKNOWN;
        bit [2:0]       gathered    = 3'd0;
        bit [2:0]       full_len    = 3'd0;
        bit [7:0]       held_bytes [6];
        mid_pkg::rec_t  owed_records [$];
        int             errors      = 0;

        static function int disp_bytes(bit [7:0] m);
            if (m[7:6] == mid_pkg::MOD_DISP8)
                return 1;
            if (m[7:6] == mid_pkg::MOD_DISP16 ||
                (m[7:6] == mid_pkg::MOD_MEM && m[2:0] == mid_pkg::RM_DIRECT))
                return 2;
            return 0;
        endfunction

        function mid_pkg::kind_t form_of(bit [7:0] b);
            if ((b & mid_pkg::MASK_REG) == mid_pkg::OP_IMM_REG) return mid_pkg::KIND_IMM_REG;
            if ((b & mid_pkg::MASK_DW) == mid_pkg::OP_RM_REG)   return mid_pkg::KIND_RM_REG;
            if ((b & mid_pkg::MASK_W) == mid_pkg::OP_MEM_ACC)   return mid_pkg::KIND_MEM_ACC;
            if ((b & mid_pkg::MASK_W) == mid_pkg::OP_ACC_MEM)   return mid_pkg::KIND_ACC_MEM;
            if ((b & mid_pkg::MASK_W) == mid_pkg::OP_IMM_RM)    return mid_pkg::KIND_IMM_RM;
            if (b == mid_pkg::OP_SEG_RM)                        return mid_pkg::KIND_SEG_RM;
            if (b == mid_pkg::OP_RM_SEG)                        return mid_pkg::KIND_RM_SEG;
            return mid_pkg::KIND_UNKNOWN;
        endfunction

        function void back_to_idle();
            gathered    = 3'd0;
            full_len    = 3'd0;
            gather_kind = mid_pkg::KIND_UNKNOWN;
        endfunction

        // Full record once every byte of the instruction is held.
        function mid_pkg::rec_t finished_record();
            mid_pkg::rec_t r;
            bit [7:0]      op;
            bit [7:0]      m;
            int            dl;
            r  = '0;
            op = held_bytes[0];
            m  = held_bytes[1];
            dl = 0;
            r.kind   = gather_kind;
            r.length = full_len;
            if (gather_kind inside {mid_pkg::KIND_RM_REG, mid_pkg::KIND_IMM_RM,
                                    mid_pkg::KIND_RM_SEG, mid_pkg::KIND_SEG_RM})
            begin
                r.mode     = m[7:6];
                r.rm_field = m[2:0];
                dl = disp_bytes(m);
                if (dl == 1)
                    r.displacement = {{8{held_bytes[2][7]}}, held_bytes[2]};
                else if (dl == 2)
                    r.displacement = {held_bytes[3], held_bytes[2]};
            end
            case (gather_kind) inside
                mid_pkg::KIND_RM_REG:
                begin
                    r.direction = op[1];
                    r.wide      = op[0];
                    r.reg_field = m[5:3];
                end
                mid_pkg::KIND_IMM_RM:
                begin
                    r.wide      = op[0];
                    r.immediate = {op[0] ? held_bytes[3 + dl] : 8'h00, held_bytes[2 + dl]};
                end
                mid_pkg::KIND_IMM_REG:
                begin
                    r.wide      = op[3];
                    r.reg_field = op[2:0];
                    r.immediate = {op[3] ? held_bytes[2] : 8'h00, held_bytes[1]};
                end
                mid_pkg::KIND_MEM_ACC, mid_pkg::KIND_ACC_MEM:
                begin
                    r.wide         = op[0];
                    r.displacement = {held_bytes[2], held_bytes[1]};
                end
                mid_pkg::KIND_RM_SEG, mid_pkg::KIND_SEG_RM:
                    r.seg_reg = op[4:3];
                default:
                    ;
            endcase
            return r;
        endfunction

        // One accepted byte: update the gather state, queue any record it causes.
        function void take_byte(bit [7:0] b, bit eos);
            mid_pkg::rec_t  r;
            mid_pkg::kind_t k;
            int             len;
            r = '0;
            if (gathered == 3'd0)
            begin
                k = form_of(b);
                if (k == mid_pkg::KIND_UNKNOWN)
                begin
                    // unknown opcode: one-byte error record, next byte is a new opcode
                    r.length = 3'd1;
                    r.error  = mid_pkg::ERR_UNKNOWN;
                    owed_records.push_back(r);
                    back_to_idle();
                    return;
                end
                held_bytes[0] = b;
                gathered      = 3'd1;
                gather_kind   = k;
                if (k == mid_pkg::KIND_IMM_REG)
                    full_len = b[3] ? 3'd3 : 3'd2;
                else if (k == mid_pkg::KIND_MEM_ACC || k == mid_pkg::KIND_ACC_MEM)
                    full_len = 3'd3;
                else
                    full_len = 3'd0;
            end
            else
            begin
                if (gathered < 3'd6)
                    held_bytes[gathered] = b;
                gathered = gathered + 3'd1;
                if (gathered == 3'd2 && full_len == 3'd0)
                begin
                    len = 2 + disp_bytes(b);
                    if (gather_kind == mid_pkg::KIND_IMM_RM)
                        len += held_bytes[0][0] ? 2 : 1;
                    full_len = 3'(len);
                end
                if (full_len != 3'd0 && gathered >= full_len)
                begin
                    owed_records.push_back(finished_record());
                    back_to_idle();
                    return;
                end
            end
            if (eos)
            begin
                // stream ended inside an instruction
                r.kind   = gather_kind;
                r.length = gathered;
                r.error  = mid_pkg::ERR_TRUNC;
                owed_records.push_back(r);
                back_to_idle();
            end
        endfunction

        function void compare_field(string what, bit [15:0] want, bit [15:0] seen);
            if (want != seen)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
                errors++;
            end
        endfunction

        function void check_record(mid_pkg::rec_t seen);
            mid_pkg::rec_t want;
            if (owed_records.size() == 0)
            begin
                $display("%0t: record with nothing owed, expected none, got kind %0d length %0d error %0d",
                         $time, seen.kind, seen.length, seen.error);
                errors++;
                return;
            end
            want = owed_records.pop_front();
            compare_field("kind", want.kind, seen.kind);
            compare_field("length", want.length, seen.length);
            compare_field("direction", want.direction, seen.direction);
            compare_field("wide", want.wide, seen.wide);
            compare_field("mode", want.mode, seen.mode);
            compare_field("reg_field", want.reg_field, seen.reg_field);
            compare_field("rm_field", want.rm_field, seen.rm_field);
            compare_field("seg_reg", want.seg_reg, seen.seg_reg);
            compare_field("displacement", want.displacement, seen.displacement);
            compare_field("immediate", want.immediate, seen.immediate);
            compare_field("error", want.error, seen.error);
        endfunction

        function int pending();
            return owed_records.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               code_valid;
    logic               code_ready;
    logic [7:0]         code_byte;
    logic               end_of_stream;
    logic               rec_valid;
    logic               rec_ready;
    logic [2:0]         kind;
    logic [2:0]         length;
    logic               direction;
    logic               wide;
    logic [1:0]         mode;
    logic [2:0]         reg_field;
    logic [2:0]         rm_field;
    logic [1:0]         seg_reg;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [1:0]         error;

    mov_record_checker sb;
    bit [7:0]          insn [$];
    int                idle_pct    = IDLE_PCT;
    int                hold_cycles = 0;
    int                bytes_sent  = 0;

    mov_instruction_byte_decoder_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .code_valid    (code_valid),
        .code_ready    (code_ready),
        .code_byte     (code_byte),
        .end_of_stream (end_of_stream),
        .rec_valid     (rec_valid),
        .rec_ready     (rec_ready),
        .kind          (kind),
        .length        (length),
        .direction     (direction),
        .wide          (wide),
        .mode          (mode),
        .reg_field     (reg_field),
        .rm_field      (rm_field),
        .seg_reg       (seg_reg),
        .displacement  (displacement),
        .immediate     (immediate),
        .error         (error)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one word; valid stays up after acceptance so back-to-back words need no second NBA.
    task automatic offer_byte(input bit [7:0] b, input bit eos);
        while ($urandom_range(99) < idle_pct)
        begin
            code_valid <= 1'b0;
            @(posedge clk);
        end
        code_valid    <= 1'b1;
        code_byte     <= b;
        end_of_stream <= eos;
        do @(posedge clk); while (!code_ready);
        sb.take_byte(b, eos);
        bytes_sent++;
    endtask

    // Send the first count bytes of insn, end-of-stream on the last if asked.
    task automatic send_list(input int count, input bit eos_last);
        for (int i = 0; i < count; i++)
            offer_byte(insn[i], eos_last && (i == count - 1));
    endtask

    // Sender pause: nothing offered until every owed record is out.
    task automatic drain_records();
        code_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Well-formed instruction of the given form with random content.
    function automatic void build_insn(mid_pkg::kind_t k);
        bit [7:0] op;
        bit [7:0] modrm;
        int       extra;
        modrm = 8'($urandom);
        if ($urandom_range(7) == 0)
        begin
            modrm[7:6] = mid_pkg::MOD_MEM;
            modrm[2:0] = mid_pkg::RM_DIRECT;
        end
        case (k)
            mid_pkg::KIND_RM_REG:  op = mid_pkg::OP_RM_REG | 8'($urandom_range(3));
            mid_pkg::KIND_IMM_RM:  op = mid_pkg::OP_IMM_RM | 8'($urandom_range(1));
            mid_pkg::KIND_IMM_REG: op = mid_pkg::OP_IMM_REG | 8'($urandom_range(15));
            mid_pkg::KIND_MEM_ACC: op = mid_pkg::OP_MEM_ACC | 8'($urandom_range(1));
            mid_pkg::KIND_ACC_MEM: op = mid_pkg::OP_ACC_MEM | 8'($urandom_range(1));
            mid_pkg::KIND_RM_SEG:  op = mid_pkg::OP_RM_SEG;
            default:               op = mid_pkg::OP_SEG_RM;
        endcase
        insn.delete();
        insn.push_back(op);
        case (k) inside
            mid_pkg::KIND_IMM_REG:                        extra = op[3] ? 2 : 1;
            mid_pkg::KIND_MEM_ACC, mid_pkg::KIND_ACC_MEM: extra = 2;
            default:
            begin
                insn.push_back(modrm);
                extra = mov_record_checker::disp_bytes(modrm);
                if (k == mid_pkg::KIND_IMM_RM)
                    extra += op[0] ? 2 : 1;
            end
        endcase
        repeat (extra) insn.push_back(8'($urandom));
    endfunction

    // Receiver: random stalls, plus a long hold-off counted down here.
    initial
    begin
        rec_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rec_valid && rec_ready)
                sb.check_record('{kind: mid_pkg::kind_t'(kind), length: length,
                                  direction: direction,
                                  wide: wide, mode: mode, reg_field: reg_field,
                                  rm_field: rm_field, seg_reg: seg_reg,
                                  displacement: displacement, immediate: immediate,
                                  error: mid_pkg::err_t'(error)});
            if (hold_cycles > 0)
            begin
                rec_ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
                rec_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int  roll;
        int  spin;
        bit  held;
        bit  paused;
        held          = 1'b0;
        paused        = 1'b0;
        sb            = new;
        rst_n         = 1'b0;
        code_valid    = 1'b0;
        code_byte     = 8'h00;
        end_of_stream = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each form, field extremes, unknown opcodes and end-of-stream cases.
        insn = {mid_pkg::OP_RM_REG | BIT_D | BIT_W, {mid_pkg::MOD_DISP8, 3'd0, 3'd6}, 8'h80};
        send_list(insn.size(), 1'b0);
        insn = {mid_pkg::OP_IMM_RM | BIT_W, {mid_pkg::MOD_DISP16, 3'd7, 3'd7},
                8'h00, 8'h80, 8'hFF, 8'hFF};
        send_list(insn.size(), 1'b0);
        // end of stream on the last byte still gives the normal record
        insn = {mid_pkg::OP_IMM_RM, {mid_pkg::MOD_MEM, 3'd0, mid_pkg::RM_DIRECT},
                8'h34, 8'h12, 8'h7F};
        send_list(insn.size(), 1'b1);
        insn = {mid_pkg::OP_IMM_REG, 8'hFF};
        send_list(insn.size(), 1'b0);
        insn = {mid_pkg::OP_MEM_ACC | BIT_W, 8'hFF, 8'hFF};
        send_list(insn.size(), 1'b0);
        // stream ends right after the opcode
        insn = {mid_pkg::OP_ACC_MEM};
        send_list(insn.size(), 1'b1);
        insn = {mid_pkg::OP_RM_SEG, {2'd3, 3'd3, 3'd0}};
        send_list(insn.size(), 1'b0);
        insn = {mid_pkg::OP_SEG_RM, {mid_pkg::MOD_MEM, 3'd0, 3'd7}};
        send_list(insn.size(), 1'b0);
        offer_byte(8'hFF, 1'b0);
        // unknown opcode carrying end of stream
        offer_byte(8'h00, 1'b1);

        // Random: mostly whole instructions, some cut short, some loose bytes.
        while (bytes_sent < RAND_BYTES + 26)
        begin
            if (bytes_sent >= 500 && !held)
            begin
                hold_cycles = 150;
                held        = 1'b1;
            end
            if (bytes_sent >= 900 && !paused)
            begin
                drain_records();
                paused = 1'b1;
            end
            idle_pct = (bytes_sent >= 1100 && bytes_sent < 1350) ? 0 : IDLE_PCT;
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                build_insn(mid_pkg::kind_t'($urandom_range(7, 1)));
                send_list(insn.size(), $urandom_range(19) == 0);
            end
            else if (roll < 88)
            begin
                build_insn(mid_pkg::kind_t'($urandom_range(7, 1)));
                send_list($urandom_range(insn.size() - 1, 1), 1'b1);
            end
            else
                offer_byte(8'($urandom), $urandom_range(7) == 0);
        end

        code_valid <= 1'b0;
        for (spin = 0; spin < 50000 && sb.pending() != 0; spin++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d records expected but never seen", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/mid_pkg.sv
hdl/mid_record.sv
hdl/mid_step.sv
hdl/mov_instruction_byte_decoder_unit.sv
sim/testbench.sv
